@@ hdl/irfe_pkg.sv @@
// Shared types, timing constants and lookup functions for the IR frame encoder.
`default_nettype none

package irfe_pkg;

  typedef enum logic [2:0] {
    PROTO_NEC     = 3'd0,
    PROTO_SAMSUNG = 3'd1,
    PROTO_SONY12  = 3'd2,
    PROTO_SONY15  = 3'd3,
    PROTO_SONY20  = 3'd4,
    PROTO_RC6     = 3'd5
  } proto_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LEAD = 2'd1,
    ST_DATA = 2'd2,
    ST_TAIL = 2'd3
  } seq_state_t;

  localparam int QDEPTH = 2;
  localparam int QPTW   = 1;

  localparam logic [15:0] TAIL_SPACE_RESET = 16'd3000;

  localparam logic [15:0] HZ_38K = 16'd38000;
  localparam logic [15:0] HZ_40K = 16'd40000;
  localparam logic [15:0] HZ_36K = 16'd36000;

  // One frame waiting for the symbol sequencer; data goes out LSB first.
  typedef struct packed {
    proto_t      proto;
    logic [31:0] bits;
  } irfe_job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } irfe_qctl_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } irfe_qstat_t;

  function automatic logic [15:0] carrier_of(input proto_t p);
    case (p)
      PROTO_NEC, PROTO_SAMSUNG:              carrier_of = HZ_38K;
      PROTO_SONY12, PROTO_SONY15, PROTO_SONY20: carrier_of = HZ_40K;
      default:                               carrier_of = HZ_36K;
    endcase
  endfunction

  // Index of the final data bit.
  function automatic logic [4:0] last_bit_of(input proto_t p);
    case (p)
      PROTO_SONY12: last_bit_of = 5'd11;
      PROTO_SONY15: last_bit_of = 5'd14;
      PROTO_SONY20: last_bit_of = 5'd19;
      PROTO_RC6:    last_bit_of = 5'd15;
      default:      last_bit_of = 5'd31;
    endcase
  endfunction

  function automatic logic [13:0] lead_mark_of(input proto_t p);
    case (p)
      PROTO_NEC:     lead_mark_of = 14'd9000;
      PROTO_SAMSUNG: lead_mark_of = 14'd4500;
      PROTO_RC6:     lead_mark_of = 14'd2664;
      default:       lead_mark_of = 14'd2400;
    endcase
  endfunction

  function automatic logic [15:0] lead_space_of(input proto_t p);
    case (p)
      PROTO_NEC, PROTO_SAMSUNG: lead_space_of = 16'd4500;
      PROTO_RC6:                lead_space_of = 16'd888;
      default:                  lead_space_of = 16'd600;
    endcase
  endfunction

  function automatic logic [13:0] bit_mark_of(input proto_t p, input logic b);
    case (p)
      PROTO_NEC:     bit_mark_of = 14'd562;
      PROTO_SAMSUNG: bit_mark_of = 14'd560;
      PROTO_RC6:     bit_mark_of = 14'd444;
      default:       bit_mark_of = b ? 14'd1200 : 14'd600;
    endcase
  endfunction

  function automatic logic [15:0] bit_space_of(input proto_t p, input logic b);
    case (p)
      PROTO_NEC:     bit_space_of = b ? 16'd1687 : 16'd562;
      PROTO_SAMSUNG: bit_space_of = b ? 16'd1690 : 16'd560;
      PROTO_RC6:     bit_space_of = b ? 16'd444 : 16'd888;
      default:       bit_space_of = 16'd600;
    endcase
  endfunction

  function automatic logic has_tail(input proto_t p);
    case (p)
      PROTO_NEC, PROTO_SAMSUNG, PROTO_RC6: has_tail = 1'b1;
      default:                             has_tail = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hdl/irfe_if.sv @@
// Valid/ready channel interfaces for the frame requests, symbols and configuration.
`default_nettype none

interface irfe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] protocol;
  logic [7:0] address;
  logic [7:0] command;

  modport source(output valid, output protocol, output address, output command,
                 input ready);
  modport sink(input valid, input protocol, input address, input command,
               output ready);
endinterface

interface irfe_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] mark_ticks;
  logic [15:0] space_ticks;
  logic [15:0] carrier_hz;
  logic        last_symbol;

  modport source(output valid, output mark_ticks, output space_ticks,
                 output carrier_hz, output last_symbol, input ready);
  modport sink(input valid, input mark_ticks, input space_ticks,
               input carrier_hz, input last_symbol, output ready);
endinterface

interface irfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] tail_space_ticks;

  modport source(output valid, output tail_space_ticks, input ready);
  modport sink(input valid, input tail_space_ticks, output ready);
endinterface

`default_nettype wire

@@ hdl/ir_remote_frame_encoder.sv @@
// Top level of the IR remote frame encoder: front end, frame queue and symbol sequencer.
`default_nettype none

// Each request (protocol, address, command) becomes one IR frame, sent as a run of
// mark/space symbols with the frame's carrier frequency; the final symbol has last_symbol
// set. NEC and Samsung frames have 34 symbols, Sony 13, 16 or 21, RC6 18. The sequencer
// emits one symbol per cycle through a registered output while the receiver is ready, and
// passes through its idle state to load each frame from the queue. A two-entry queue holds
// frames ahead of the sequencer, so requests are taken while a frame is being sent.
// Requests with an unknown protocol code (6 or 7) are taken and produce no symbols. The
// tail space register resets to 3000 ticks and should be written only while no frame is
// pending.
module ir_remote_frame_encoder
  import irfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  irfe_in_if.sink    in_ch,
  irfe_cfg_if.sink   cfg_ch,
  irfe_out_if.source out_ch
);

  irfe_qctl_t  q_ctl;
  irfe_qstat_t q_stat;
  irfe_job_t   wr_job;
  irfe_job_t   rd_job;
  logic        q_push;
  logic        q_pop;

  assign q_ctl.push = q_push;
  assign q_ctl.pop  = q_pop;

  irfe_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_job  (wr_job)
  );

  irfe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .wr_job (wr_job),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  irfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_job  (rd_job),
    .q_pop  (q_pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ hdl/irfe_front.sv @@
// Request front end: accepts requests, drops unknown protocols and builds the frame word.
`default_nettype none

module irfe_front
  import irfe_pkg::*;
(
  irfe_in_if.sink           in_ch,
  input  irfe_qstat_t       q_stat,
  output logic              q_push,
  output irfe_job_t         q_job
);

  logic        known;
  logic [15:0] rc6_word;
  logic [15:0] rc6_rev;

  assign in_ch.ready = !q_stat.full;
  assign known       = (in_ch.protocol <= PROTO_RC6);
  assign q_push      = in_ch.valid && in_ch.ready && known;

  assign rc6_word = {in_ch.address, in_ch.command};

  // RC6 goes out MSB first, so store it reversed for the LSB-first sequencer.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rc6_rev[i] = rc6_word[15 - i];
    end
  end

  always_comb begin
    q_job.proto = proto_t'(in_ch.protocol);
    case (in_ch.protocol)
      PROTO_NEC: begin
        q_job.bits = {~in_ch.command, in_ch.command, ~in_ch.address, in_ch.address};
      end
      PROTO_SAMSUNG: begin
        q_job.bits = {in_ch.command, in_ch.command, in_ch.address, in_ch.address};
      end
      PROTO_SONY12, PROTO_SONY15, PROTO_SONY20: begin
        q_job.bits = {20'd0, in_ch.address[4:0], in_ch.command[6:0]};
      end
      default: begin
        q_job.bits = {16'd0, rc6_rev};
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/irfe_queue.sv @@
// Two-entry frame queue between the request front end and the symbol sequencer.
`default_nettype none

module irfe_queue
  import irfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  irfe_qctl_t  ctl,
  input  irfe_job_t   wr_job,
  output irfe_job_t   rd_job,
  output irfe_qstat_t stat
);

  irfe_job_t         mem_r [QDEPTH];
  logic [QPTW-1:0]   wr_ptr_r;
  logic [QPTW-1:0]   rd_ptr_r;
  logic [QPTW:0]     count_r;
  logic [QPTW-1:0]   wr_ptr_nxt;
  logic [QPTW-1:0]   rd_ptr_nxt;
  logic [QPTW:0]     count_nxt;

  assign stat.full     = (count_r == (QPTW + 1)'(QDEPTH));
  assign stat.nonempty = (count_r != '0);
  assign rd_job        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

@@ hdl/irfe_back.sv @@
// Symbol sequencer: walks one frame at a time and emits its mark/space symbols.
`default_nettype none

module irfe_back
  import irfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  irfe_qstat_t   q_stat,
  input  irfe_job_t     q_job,
  output logic          q_pop,
  irfe_cfg_if.sink      cfg_ch,
  irfe_out_if.source    out_ch
);

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  proto_t      proto_r;
  logic [31:0] bits_r;
  logic [4:0]  idx_r;
  logic [15:0] tail_r;

  logic        out_valid_r;
  logic [13:0] out_mark_r;
  logic [15:0] out_space_r;
  logic [15:0] out_hz_r;
  logic        out_last_r;

  logic        load;
  logic        last_bit;
  logic [13:0] sym_mark;
  logic [15:0] sym_space;
  logic        sym_last;

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mark_ticks  = out_mark_r;
  assign out_ch.space_ticks = out_space_r;
  assign out_ch.carrier_hz  = out_hz_r;
  assign out_ch.last_symbol = out_last_r;

  assign last_bit = (idx_r == last_bit_of(proto_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_stat.nonempty) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (load) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (load && last_bit) begin
          state_nxt = has_tail(proto_r) ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: the symbol for the current step and the load/pop strobes.
  always_comb begin
    load      = (state_r != ST_IDLE) && (!out_valid_r || out_ch.ready);
    q_pop     = (state_r == ST_IDLE) && q_stat.nonempty;
    sym_mark  = lead_mark_of(proto_r);
    sym_space = lead_space_of(proto_r);
    sym_last  = 1'b0;
    case (state_r)
      ST_DATA: begin
        sym_mark  = bit_mark_of(proto_r, bits_r[0]);
        sym_space = bit_space_of(proto_r, bits_r[0]);
        sym_last  = last_bit && !has_tail(proto_r);
      end
      ST_TAIL: begin
        sym_mark  = bit_mark_of(proto_r, 1'b0);
        sym_space = tail_r;
        sym_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tail_r      <= TAIL_SPACE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tail_r <= cfg_ch.tail_space_ticks;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      proto_r <= q_job.proto;
      bits_r  <= q_job.bits;
      idx_r   <= '0;
    end else if (load && state_r == ST_DATA) begin
      bits_r <= {1'b0, bits_r[31:1]};
      idx_r  <= idx_r + 1'b1;
    end
    if (load) begin
      out_mark_r  <= sym_mark;
      out_space_r <= sym_space;
      out_hz_r    <= carrier_of(proto_r);
      out_last_r  <= sym_last;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the IR remote frame encoder: directed frames, then random traffic.
`default_nettype none

module tb_top;
  import irfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Protocol codes the encoder must swallow without sending a frame.
  localparam logic [2:0] PROTO_BAD6 = 3'd6;
  localparam logic [2:0] PROTO_BAD7 = 3'd7;

  localparam int SETTLE_CYCLES = 40;
  localparam int N_RANDOM      = 387;
  localparam int N_DIR         = 23;

  typedef struct packed {
    logic [13:0] mark;
    logic [15:0] space;
    logic [15:0] hz;
    logic        last;
  } ir_symbol_t;

  typedef enum bit {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] tail;
    logic [2:0]  code;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    bit          pinned;      // final symbol's mark/space typed in below
    logic [13:0] end_mark;
    logic [15:0] end_space;
  } dir_row_t;

  logic clk;
  logic rst_n;

  irfe_in_if  in_if();
  irfe_out_if out_if();
  irfe_cfg_if cfg_if();

  ir_remote_frame_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  ir_symbol_t  due_symbols[$];
  logic [15:0] tail_shadow;
  int          errs;
  int          send_idle_pct;
  int          recv_stall_pct;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_FRAME, 16'd0,     PROTO_NEC,     8'h00, 8'h00, 1'b1, 14'd562,  16'd3000},
    '{ROW_FRAME, 16'd0,     PROTO_NEC,     8'hff, 8'hff, 1'b1, 14'd562,  16'd3000},
    '{ROW_FRAME, 16'd0,     PROTO_SAMSUNG, 8'h00, 8'h00, 1'b1, 14'd560,  16'd3000},
    '{ROW_FRAME, 16'd0,     PROTO_SAMSUNG, 8'hff, 8'hff, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_SONY12,  8'h00, 8'h00, 1'b1, 14'd600,  16'd600},
    '{ROW_FRAME, 16'd0,     PROTO_SONY12,  8'hff, 8'hff, 1'b1, 14'd1200, 16'd600},
    '{ROW_FRAME, 16'd0,     PROTO_SONY15,  8'hff, 8'hff, 1'b1, 14'd600,  16'd600},
    '{ROW_FRAME, 16'd0,     PROTO_SONY15,  8'h5a, 8'ha5, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_SONY20,  8'hff, 8'hff, 1'b1, 14'd600,  16'd600},
    '{ROW_FRAME, 16'd0,     PROTO_SONY20,  8'h00, 8'h00, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_RC6,     8'h00, 8'h00, 1'b1, 14'd444,  16'd3000},
    '{ROW_FRAME, 16'd0,     PROTO_RC6,     8'hff, 8'hff, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_BAD6,    8'hff, 8'hff, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_BAD7,    8'h00, 8'h00, 1'b0, 14'd0,    16'd0},
    '{ROW_CFG,   16'd0,     PROTO_NEC,     8'h00, 8'h00, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_NEC,     8'h55, 8'haa, 1'b1, 14'd562,  16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_RC6,     8'h12, 8'h34, 1'b1, 14'd444,  16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_SAMSUNG, 8'h80, 8'h01, 1'b0, 14'd0,    16'd0},
    '{ROW_CFG,   16'hffff,  PROTO_NEC,     8'h00, 8'h00, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_NEC,     8'ha5, 8'h5a, 1'b1, 14'd562,  16'd65535},
    '{ROW_FRAME, 16'd0,     PROTO_RC6,     8'hff, 8'h00, 1'b1, 14'd444,  16'd65535},
    '{ROW_FRAME, 16'd0,     PROTO_BAD7,    8'hff, 8'hff, 1'b0, 14'd0,    16'd0},
    '{ROW_FRAME, 16'd0,     PROTO_SONY12,  8'h1f, 8'h7f, 1'b1, 14'd1200, 16'd600}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_symbol(input logic [13:0] mark, input logic [15:0] space,
                                      input logic [15:0] hz, input logic last);
    ir_symbol_t s;
    s.mark  = mark;
    s.space = space;
    s.hz    = hz;
    s.last  = last;
    due_symbols.insert(due_symbols.size(), s);
  endfunction

  // Appends the symbols of one frame to the list of symbols still owed by the encoder.
  function automatic void encode_frame(input logic [2:0] code, input logic [7:0] addr,
                                       input logic [7:0] cmd);
    proto_t      p;
    logic [31:0] word;
    int          nbits;
    if (code > PROTO_RC6) return;
    p = proto_t'(code);
    case (p)
      PROTO_NEC: begin
        word = {~cmd, cmd, ~addr, addr};
        push_symbol(14'd9000, 16'd4500, 16'd38000, 1'b0);
        for (int i = 0; i < 32; i++)
          push_symbol(14'd562, word[i] ? 16'd1687 : 16'd562, 16'd38000, 1'b0);
        push_symbol(14'd562, tail_shadow, 16'd38000, 1'b1);
      end
      PROTO_SAMSUNG: begin
        word = {cmd, cmd, addr, addr};
        push_symbol(14'd4500, 16'd4500, 16'd38000, 1'b0);
        for (int i = 0; i < 32; i++)
          push_symbol(14'd560, word[i] ? 16'd1690 : 16'd560, 16'd38000, 1'b0);
        push_symbol(14'd560, tail_shadow, 16'd38000, 1'b1);
      end
      PROTO_RC6: begin
        word = {16'd0, addr, cmd};
        push_symbol(14'd2664, 16'd888, 16'd36000, 1'b0);
        for (int i = 15; i >= 0; i--)
          push_symbol(14'd444, word[i] ? 16'd444 : 16'd888, 16'd36000, 1'b0);
        push_symbol(14'd444, tail_shadow, 16'd36000, 1'b1);
      end
      default: begin
        nbits = (p == PROTO_SONY12) ? 12 : (p == PROTO_SONY15) ? 15 : 20;
        word  = {20'd0, addr[4:0], cmd[6:0]};
        push_symbol(14'd2400, 16'd600, 16'd40000, 1'b0);
        for (int i = 0; i < nbits; i++)
          push_symbol(word[i] ? 14'd1200 : 14'd600, 16'd600, 16'd40000, i == nbits - 1);
      end
    endcase
  endfunction

  function automatic void note_error(input string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endfunction

  // Valid is left high after a transfer so back-to-back requests never toggle it.
  task automatic send_request(input logic [2:0] code, input logic [7:0] addr,
                              input logic [7:0] cmd, input bit pinned,
                              input logic [13:0] end_mark, input logic [15:0] end_space);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.protocol <= code;
    in_if.address  <= addr;
    in_if.command  <= cmd;
    do @(posedge clk); while (!in_if.ready);
    encode_frame(code, addr, cmd);
    if (pinned) begin
      due_symbols[$].mark  = end_mark;
      due_symbols[$].space = end_space;
    end
  endtask

  // Unknown-protocol requests leave no symbols behind, so a settling pause follows.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (due_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tail(input logic [15:0] value);
    cfg_if.valid            <= 1'b1;
    cfg_if.tail_space_ticks <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tail_shadow = value;
  endtask

  // Symbol checker and output back-pressure.
  initial begin
    ir_symbol_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (due_symbols.size() == 0) begin
          note_error($sformatf("unexpected symbol %0d/%0d/%0d/%0b", out_if.mark_ticks,
                               out_if.space_ticks, out_if.carrier_hz, out_if.last_symbol));
        end else begin
          want = due_symbols.pop_front();
          if (out_if.mark_ticks !== want.mark || out_if.space_ticks !== want.space ||
              out_if.carrier_hz !== want.hz || out_if.last_symbol !== want.last) begin
            note_error($sformatf("symbol mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.mark, want.space, want.hz, want.last,
                                 out_if.mark_ticks, out_if.space_ticks,
                                 out_if.carrier_hz, out_if.last_symbol));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [2:0]  code;
    logic [15:0] phase_tail;
    errs           = 0;
    tail_shadow    = TAIL_SPACE_RESET;
    send_idle_pct  = 30;
    recv_stall_pct = 60;
    rst_n                   <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.protocol          <= 3'd0;
    in_if.address           <= 8'd0;
    in_if.command           <= 8'd0;
    cfg_if.valid            <= 1'b0;
    cfg_if.tail_space_ticks <= 16'd0;
    out_if.ready            <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_tail(dir_rows[r].tail);
      end else begin
        send_request(dir_rows[r].code, dir_rows[r].addr, dir_rows[r].cmd,
                     dir_rows[r].pinned, dir_rows[r].end_mark, dir_rows[r].end_space);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      send_idle_pct  = (ph == 0) ? 30 : (ph == 1) ? 60 : 0;
      recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 30 : 0;
      phase_tail = (ph == 0) ? 16'($urandom_range(65534, 1)) : (ph == 1) ? 16'd1 : 16'hffff;
      write_tail(phase_tail);
      for (int n = 0; n < N_RANDOM / 3 + 1; n++) begin
        // Mostly real frames; a tenth of the requests carry an unknown protocol.
        if ($urandom_range(9) == 0)
          code = ($urandom_range(1) == 0) ? PROTO_BAD6 : PROTO_BAD7;
        else
          code = 3'($urandom_range(5));
        send_request(code, 8'($urandom), 8'($urandom), 1'b0, 14'd0, 16'd0);
      end
    end

    in_if.valid <= 1'b0;
    while (due_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errs == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/irfe_pkg.sv
hdl/irfe_if.sv
hdl/irfe_front.sv
hdl/irfe_queue.sv
hdl/irfe_back.sv
hdl/ir_remote_frame_encoder.sv
tb/sv/tb_top.sv
